// File: rtl/core/clpm_pkg.sv
// clpm_pkg: shared widths, codes, types and helpers for the callsign prefix matcher
// no dependencies; used by clpm_ctrl, clpm_dp, the top level and the checker
`default_nettype none

package clpm_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 2048;
    localparam int MAX_CHARS   = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // fixed field widths
    localparam int CFG_W   = 12;
    localparam int ENTRY_W = 11;
    localparam int TEXT_W  = 64;
    localparam int LEN_W   = 4;
    localparam int CTRY_W  = 10;
    localparam int CHAR_W  = 8;

    // width wide enough to hold both the register value and the table depth
    localparam int SAT_W = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;

    // item command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // one stored table entry
    typedef struct packed {
        logic [TEXT_W-1:0] text;
        logic [LEN_W-1:0]  len;
        logic [CTRY_W-1:0] ctry;
    } t_entry;

    // commands from the controller to the datapath
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             call_load;
        logic             best_clear;
        logic             out_load;
    } t_dp_cmd;

    // fold a-z to upper case
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7a) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // saturate a character count at MAX_CHARS
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l);
        logic [LEN_W-1:0] r;
        r = l;
        if (l > LEN_W'(MAX_CHARS)) begin
            r = LEN_W'(MAX_CHARS);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/clpm_dp.sv
// clpm_dp: entry memory, registered read, compare against the call and best-match registers
// depends on clpm_pkg; driven by clpm_ctrl through clpm_pkg::t_dp_cmd
`default_nettype none

module clpm_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire clpm_pkg::t_dp_cmd            i_cmd,
    input  wire logic [clpm_pkg::ENTRY_W-1:0] i_entry_index,
    input  wire logic [clpm_pkg::TEXT_W-1:0]  i_text_chars,
    input  wire logic [clpm_pkg::LEN_W-1:0]   i_text_length,
    input  wire logic [clpm_pkg::CTRY_W-1:0]  i_country_number,
    output logic                              o_found,
    output logic [clpm_pkg::CTRY_W-1:0]       o_matched_country,
    output logic [clpm_pkg::LEN_W-1:0]        o_match_length
);

    // entry memory and its registered read port
    clpm_pkg::t_entry r_mem [clpm_pkg::TABLE_DEPTH];
    clpm_pkg::t_entry r_rd;
    logic             r_rd_vld;

    // folded call under lookup
    logic [clpm_pkg::TEXT_W-1:0] r_call_text;
    logic [clpm_pkg::LEN_W-1:0]  r_call_len;
    logic [clpm_pkg::TEXT_W-1:0] call_fold;

    // best match so far
    logic                        r_found;
    logic [clpm_pkg::LEN_W-1:0]  r_best_len;
    logic [clpm_pkg::CTRY_W-1:0] r_best_ctry;

    // output register
    logic                        r_out_found;
    logic [clpm_pkg::CTRY_W-1:0] r_out_ctry;
    logic [clpm_pkg::LEN_W-1:0]  r_out_len;

    logic [clpm_pkg::MAX_CHARS-1:0] char_ok;
    logic                           len_ok;
    logic                           match;
    logic                           better;

    // memory write and read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[clpm_pkg::IDX_W'(i_entry_index)] <= '{
                text: i_text_chars,
                len:  clpm_pkg::clamp_len(i_text_length),
                ctry: i_country_number
            };
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
    end

    // fold each character of the incoming call to upper case
    always_comb begin
        call_fold = '0;
        for (int i = 0; i < clpm_pkg::MAX_CHARS; i++) begin
            call_fold[clpm_pkg::TEXT_W-1-clpm_pkg::CHAR_W*i -: clpm_pkg::CHAR_W] =
                clpm_pkg::fold_char(
                    i_text_chars[clpm_pkg::TEXT_W-1-clpm_pkg::CHAR_W*i -: clpm_pkg::CHAR_W]);
        end
    end

    // compare the entry read last cycle against the call
    always_comb begin
        len_ok = (r_rd.len <= r_call_len);
        for (int i = 0; i < clpm_pkg::MAX_CHARS; i++) begin
            char_ok[i] = (clpm_pkg::LEN_W'(i) >= r_rd.len) ||
                (clpm_pkg::fold_char(
                    r_rd.text[clpm_pkg::TEXT_W-1-clpm_pkg::CHAR_W*i -: clpm_pkg::CHAR_W]) ==
                 r_call_text[clpm_pkg::TEXT_W-1-clpm_pkg::CHAR_W*i -: clpm_pkg::CHAR_W]);
        end
        match  = r_rd_vld && len_ok && (&char_ok);
        // strictly longer only, so the earlier entry keeps a tie
        better = match && (!r_found || (r_rd.len > r_best_len));
    end

    // read valid and found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.best_clear) begin
                r_found <= 1'b0;
            end else if (better) begin
                r_found <= 1'b1;
            end
        end
    end

    // call, best and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.call_load) begin
            r_call_text <= call_fold;
            r_call_len  <= clpm_pkg::clamp_len(i_text_length);
        end
        if (i_cmd.best_clear) begin
            r_best_len  <= '0;
            r_best_ctry <= '0;
        end else if (better) begin
            r_best_len  <= r_rd.len;
            r_best_ctry <= r_rd.ctry;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_found;
            r_out_ctry  <= r_best_ctry;
            r_out_len   <= r_best_len;
        end
    end

    assign o_found           = r_out_found;
    assign o_matched_country = r_out_ctry;
    assign o_match_length    = r_out_len;

endmodule

`default_nettype wire

// File: rtl/core/clpm_ctrl.sv
// clpm_ctrl: sequencer for loads and table scans, entries_in_use register and result valid
// depends on clpm_pkg; commands clpm_dp through clpm_pkg::t_dp_cmd
`default_nettype none

module clpm_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_cmd,
    input  wire logic [clpm_pkg::ENTRY_W-1:0] i_entry_index,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    input  wire logic                         i_cfg_we,
    input  wire logic [clpm_pkg::CFG_W-1:0]   i_cfg_wdata,
    output clpm_pkg::t_dp_cmd                 o_dp_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state                     r_state, n_state;
    logic [clpm_pkg::IDX_W-1:0] r_addr, n_addr;
    logic [clpm_pkg::IDX_W-1:0] r_last, n_last;
    logic [clpm_pkg::CFG_W-1:0] r_cfg, n_cfg;
    logic                       r_out_valid, n_out_valid;

    logic [clpm_pkg::SAT_W-1:0] n_sat;
    logic                       in_acc;
    logic                       out_free;

    // entries to scan, saturated at the table depth
    always_comb begin
        n_sat = (clpm_pkg::SAT_W'(r_cfg) > clpm_pkg::SAT_W'(clpm_pkg::TABLE_DEPTH)) ?
                clpm_pkg::SAT_W'(clpm_pkg::TABLE_DEPTH) : clpm_pkg::SAT_W'(r_cfg);
    end

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_last      = r_last;
        n_cfg       = r_cfg;
        n_out_valid = r_out_valid && i_out_stall;
        o_dp_cmd    = '0;
        o_dp_cmd.rd_addr = r_addr;

        if (i_cfg_we) begin
            n_cfg = i_cfg_wdata;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == clpm_pkg::CMD_LOAD) begin
                        // slots beyond the table are dropped
                        o_dp_cmd.wr_en = (32'(i_entry_index) < clpm_pkg::TABLE_DEPTH);
                    end else begin
                        o_dp_cmd.call_load  = 1'b1;
                        o_dp_cmd.best_clear = 1'b1;
                        n_addr = '0;
                        n_last = clpm_pkg::IDX_W'(n_sat - clpm_pkg::SAT_W'(1));
                        // empty table gives not found straight away
                        n_state = (n_sat == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_dp_cmd.rd_en = 1'b1;
                n_addr = r_addr + clpm_pkg::IDX_W'(1);
                if (r_addr == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read is compared this cycle
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_dp_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_last      <= '0;
            r_cfg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_last      <= n_last;
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/core/callsign_prefix_longest_match.sv
// callsign_prefix_longest_match: top level of the callsign longest-prefix matcher
// depends on clpm_pkg, clpm_ctrl and clpm_dp
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------------
//  in      | input     | i_in_valid / o_in_stall  | cmd, entry_index, text_chars, text_length,
//          |           |                          | country_number
//  out     | output    | o_out_valid / i_out_stall| found, matched_country, match_length
//  cfg     | input     | i_cfg_we                 | i_cfg_wdata (entries_in_use)
//
// a load item is written as it is accepted and the next item can follow at once
// a lookup item scans N entries, N being entries_in_use saturated at 2048, one per cycle
// through the single read port of the entry memory; the result is loaded in the done state,
// reached via a drain state after the scan, or directly when N is 0; input stalls until then
// reset clears the controller and entries_in_use; table contents are undefined until loaded
// a stalled result holds while the next item is accepted; a finished scan waits for it to leave
`default_nettype none

module callsign_prefix_longest_match (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_cmd,
    input  wire logic [clpm_pkg::ENTRY_W-1:0] i_entry_index,
    input  wire logic [clpm_pkg::TEXT_W-1:0]  i_text_chars,
    input  wire logic [clpm_pkg::LEN_W-1:0]   i_text_length,
    input  wire logic [clpm_pkg::CTRY_W-1:0]  i_country_number,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_found,
    output logic [clpm_pkg::CTRY_W-1:0]       o_matched_country,
    output logic [clpm_pkg::LEN_W-1:0]        o_match_length,
    input  wire logic                         i_cfg_we,
    input  wire logic [clpm_pkg::CFG_W-1:0]   i_cfg_wdata
);

    clpm_pkg::t_dp_cmd dp_cmd;

    // sequencer
    clpm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_cmd         (i_cmd),
        .i_entry_index (i_entry_index),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_dp_cmd      (dp_cmd)
    );

    // table memory and compare
    clpm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .i_entry_index     (i_entry_index),
        .i_text_chars      (i_text_chars),
        .i_text_length     (i_text_length),
        .i_country_number  (i_country_number),
        .o_found           (o_found),
        .o_matched_country (o_matched_country),
        .o_match_length    (o_match_length)
    );

endmodule

`default_nettype wire

// File: rtl/core/clpm_checker.sv
// clpm_checker: port-level assertions for callsign_prefix_longest_match, bound to the top level
// depends on clpm_pkg
`default_nettype none

module clpm_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         o_in_stall,
    input  wire logic                         i_cmd,
    input  wire logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    input  wire logic                         o_found,
    input  wire logic [clpm_pkg::CTRY_W-1:0]  o_matched_country,
    input  wire logic [clpm_pkg::LEN_W-1:0]   o_match_length
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_found) &&
            $stable(o_matched_country) && $stable(o_match_length))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result valid or stall after reset");

    // a miss reports zero country and zero length
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_matched_country == '0 && o_match_length == '0)
        else $error("not-found result with nonzero payload");

    // a load leaves the input open, a lookup closes it while the table is scanned
    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_cmd == clpm_pkg::CMD_LOAD |=> !o_in_stall)
        else $error("stall after a load item");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_cmd == clpm_pkg::CMD_LOOKUP |=> o_in_stall)
        else $error("no stall after a lookup item");

endmodule

bind callsign_prefix_longest_match clpm_checker u_clpm_checker (.*);

`default_nettype wire
